// ----- sv/pcf_pkg.sv -----
// shared types, constants and helpers for the printf conversion formatter
`timescale 1ns / 1ps
package pcf_pkg;

  // conversion kinds
  localparam logic [2:0] KIND_SDEC    = 3'd0;
  localparam logic [2:0] KIND_UDEC    = 3'd1;
  localparam logic [2:0] KIND_HEX_LO  = 3'd2;
  localparam logic [2:0] KIND_HEX_UP  = 3'd3;
  localparam logic [2:0] KIND_PTR     = 3'd4;
  localparam logic [2:0] KIND_CHAR    = 3'd5;
  localparam logic [2:0] KIND_PERCENT = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  // digit register geometry
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIG    = 20;
  localparam int unsigned DIG_W      = NUM_DIG * 4;
  localparam int unsigned HEX_DIG    = VALUE_W / 4;
  localparam int unsigned BITS_STEP  = 4;
  localparam int unsigned CONV_STEPS = VALUE_W / BITS_STEP;

  // ascii characters
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_UP_OFS  = 8'h37;
  localparam logic [7:0] CH_LO_OFS  = 8'h57;

  typedef struct packed {
    logic [2:0]  kind;
    logic        is_long;
    logic [63:0] value;
    logic [7:0]  symbol;
  } pcf_in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } pcf_out_t;

  // one digit 0..15 to ascii, letters in the chosen case
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else if (upper) begin
      ch = CH_UP_OFS + {4'b0, d};
    end else begin
      ch = CH_LO_OFS + {4'b0, d};
    end
    return ch;
  endfunction

endpackage

// ----- sv/pcf_dabble.sv -----
// shared shift-and-add-3 unit: four binary bits into the bcd register per cycle
`timescale 1ns / 1ps
module pcf_dabble (
  input  logic [pcf_pkg::DIG_W-1:0]     bcd_i,
  input  logic [pcf_pkg::BITS_STEP-1:0] bits_i,
  output logic [pcf_pkg::DIG_W-1:0]     bcd_o
);
  import pcf_pkg::*;

  logic [DIG_W-1:0] bcd_v;

  always_comb begin
    bcd_v = bcd_i;
    for (int s = 0; s < BITS_STEP; s++) begin
      for (int d = 0; d < NUM_DIG; d++) begin
        if (bcd_v[d*4 +: 4] >= 4'd5) begin
          bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
        end
      end
      // msb first
      bcd_v = {bcd_v[DIG_W-2:0], bits_i[BITS_STEP-1-s]};
    end
    bcd_o = bcd_v;
  end

endmodule

// ----- sv/pcf_out_stage.sv -----
// output register that holds one word while the receiver stalls
`timescale 1ns / 1ps
module pcf_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pcf_pkg::pcf_out_t word_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcf_pkg::pcf_out_t out_o
);
  import pcf_pkg::*;

  logic     valid_q;
  pcf_out_t word_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ----- sv/printf_conversion_formatter.sv -----
// top level of the printf conversion formatter: sequencer, digit store and output
`timescale 1ns / 1ps
// Formats one conversion request per word into ASCII text, one character
// per output word, most significant digit first, with last set on the final
// character. The block takes one request at a time and stalls its input until
// the last character has been handed to the output register. Decimal kinds run
// the value through one shared shift-and-add-3 unit, four bits per cycle; then
// the 20-digit register is scanned one digit per cycle while the output does
// not stall, leading zeros being skipped without output. A negative signed
// value is preceded by a minus sign. Hex and pointer kinds skip the conversion
// and scan 16 nibbles, pointers after a 0x prefix. Char, percent and unknown
// directive kinds send one to three literal characters. Stalls on the output
// hold the sequencer until the stalled character is taken.
module printf_conversion_formatter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pcf_pkg::pcf_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pcf_pkg::pcf_out_t out_o
);
  import pcf_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [23:0]        lit_q, lit_d;          // up to three literal chars, top first
  logic [1:0]         lit_cnt_q, lit_cnt_d;
  logic               has_num_q, has_num_d;  // digits follow the literals
  logic               upper_q, upper_d;
  logic               started_q, started_d;  // first significant digit seen
  logic [DIG_W-1:0]   dig_q, dig_d;          // bcd or hex digits, top digit first
  logic [VALUE_W-1:0] sh_q, sh_d;            // binary bits still to convert
  logic [3:0]         cnt_q, cnt_d;          // conversion steps left after the current one
  logic [4:0]         rem_q, rem_d;          // digit slots left

  logic               in_fire;
  logic [VALUE_W-1:0] sext_v;
  logic [VALUE_W-1:0] zext_v;
  logic [VALUE_W-1:0] mag_v;
  logic               neg_v;
  logic [DIG_W-1:0]   dabble_out;

  logic               emit_valid;
  logic               emit_ready;
  logic               emit_fire;
  pcf_out_t           emit_word;
  logic [3:0]         top_dig;
  logic               skip_zero;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && (state_q == S_IDLE);

  // operand preparation
  assign sext_v = in_i.is_long ? in_i.value : {{32{in_i.value[31]}}, in_i.value[31:0]};
  assign zext_v = in_i.is_long ? in_i.value : {32'b0, in_i.value[31:0]};
  assign neg_v  = (in_i.kind == KIND_SDEC) && sext_v[VALUE_W-1];

  always_comb begin
    case (in_i.kind)
      KIND_SDEC: mag_v = neg_v ? (~sext_v + 64'd1) : sext_v;
      KIND_PTR:  mag_v = in_i.value;
      default:   mag_v = zext_v;
    endcase
  end

  pcf_dabble u_dabble (
    .bcd_i  (dig_q),
    .bits_i (sh_q[VALUE_W-1 -: BITS_STEP]),
    .bcd_o  (dabble_out)
  );

  // character selection for the current slot
  assign top_dig   = dig_q[DIG_W-1 -: 4];
  assign skip_zero = (state_q == S_EMIT) && (lit_cnt_q == 2'd0) && has_num_q &&
                     !started_q && (top_dig == 4'd0) && (rem_q != 5'd1);

  always_comb begin
    emit_valid = 1'b0;
    emit_word  = '0;
    if (state_q == S_EMIT) begin
      if (lit_cnt_q != 2'd0) begin
        emit_valid          = 1'b1;
        emit_word.text_char = lit_q[23:16];
        emit_word.last      = (lit_cnt_q == 2'd1) && !has_num_q;
      end else if (!skip_zero) begin
        emit_valid          = 1'b1;
        emit_word.text_char = digit_char(top_dig, upper_q);
        emit_word.last      = (rem_q == 5'd1);
      end
    end
  end

  assign emit_fire = emit_valid && emit_ready;

  always_comb begin
    state_d   = state_q;
    lit_d     = lit_q;
    lit_cnt_d = lit_cnt_q;
    has_num_d = has_num_q;
    upper_d   = upper_q;
    started_d = started_q;
    dig_d     = dig_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          started_d = 1'b0;
          upper_d   = (in_i.kind == KIND_HEX_UP);
          has_num_d = (in_i.kind inside {[KIND_SDEC:KIND_PTR]});
          lit_d     = '0;
          lit_cnt_d = 2'd0;
          case (in_i.kind)
            KIND_SDEC: begin
              if (neg_v) begin
                lit_d     = {CH_MINUS, 16'h0};
                lit_cnt_d = 2'd1;
              end
            end
            KIND_PTR: begin
              lit_d     = {CH_ZERO, CH_X, 8'h0};
              lit_cnt_d = 2'd2;
            end
            KIND_CHAR: begin
              lit_d     = {in_i.symbol, 16'h0};
              lit_cnt_d = 2'd1;
            end
            KIND_PERCENT: begin
              lit_d     = {CH_PERCENT, 16'h0};
              lit_cnt_d = 2'd1;
            end
            KIND_UNKNOWN: begin
              lit_d     = {CH_PERCENT, 16'h0};
              lit_cnt_d = 2'd1;
              if (in_i.is_long) begin
                lit_d[15:8] = CH_L;
                lit_cnt_d   = 2'd2;
                if (in_i.symbol != 8'd0) begin
                  lit_d[7:0] = in_i.symbol;
                  lit_cnt_d  = 2'd3;
                end
              end else if (in_i.symbol != 8'd0) begin
                lit_d[15:8] = in_i.symbol;
                lit_cnt_d   = 2'd2;
              end
            end
            default: ;
          endcase
          if (in_i.kind inside {KIND_SDEC, KIND_UDEC}) begin
            // binary to bcd first
            sh_d    = mag_v;
            dig_d   = '0;
            cnt_d   = 4'(CONV_STEPS - 1);
            state_d = S_CONV;
          end else begin
            dig_d   = {mag_v, {(DIG_W-VALUE_W){1'b0}}};
            rem_d   = 5'(HEX_DIG);
            state_d = S_EMIT;
          end
        end
      end
      S_CONV: begin
        dig_d = dabble_out;
        sh_d  = {sh_q[VALUE_W-BITS_STEP-1:0], {BITS_STEP{1'b0}}};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          rem_d   = 5'(NUM_DIG);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (lit_cnt_q != 2'd0) begin
          if (emit_fire) begin
            lit_d     = {lit_q[15:0], 8'h0};
            lit_cnt_d = lit_cnt_q - 2'd1;
            if (emit_word.last) begin
              state_d = S_IDLE;
            end
          end
        end else if (skip_zero || emit_fire) begin
          dig_d = {dig_q[DIG_W-5:0], 4'h0};
          rem_d = rem_q - 5'd1;
          if (emit_fire) begin
            started_d = 1'b1;
            if (emit_word.last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lit_cnt_q <= 2'd0;
      has_num_q <= 1'b0;
      upper_q   <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= 4'd0;
      rem_q     <= 5'd0;
    end else begin
      state_q   <= state_d;
      lit_cnt_q <= lit_cnt_d;
      has_num_q <= has_num_d;
      upper_q   <= upper_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lit_q <= lit_d;
    dig_q <= dig_d;
    sh_q  <= sh_d;
  end

  pcf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (emit_valid),
    .word_i      (emit_word),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // a taken request holds the input off while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // the final character returns the sequencer to idle
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_word.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after the final character");

  // once literals are gone, digits must remain
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && (lit_cnt_q == 2'd0)) |-> (has_num_q && (rem_q != 5'd0)))
    else $error("emit state with nothing left to send");

  // nothing is produced while converting
  a_quiet_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !emit_valid)
    else $error("character produced during conversion");

endmodule
